FILE: rtl/core/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// sizes, action and status codes, controller-to-datapath command bundle
// ---------------------------------------------------------------------------
package ple_pkg;

    // list capacity, legal range 2 to 64
    localparam int unsigned DEPTH = 16;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int unsigned ACT_W     = 3;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned EIDX_W    = 6;
    localparam int unsigned ECNT_W    = 7;
    localparam int unsigned ST_W      = 2;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_RM_FRONT  = 3'd3,
        ACT_RM_BACK   = 3'd4,
        ACT_RM_AT     = 3'd5,
        ACT_CLAMP     = 3'd6,
        ACT_DUMP      = 3'd7
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        WR_VALUE = 2'd0,
        WR_RDATA = 2'd1,
        WR_CLAMP = 2'd2
    } wr_src_t;

    typedef enum logic [1:0] {
        CNT_KEEP = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    // controller to datapath
    typedef struct packed {
        logic             val_load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        wr_src_t          wr_src;
        cnt_op_t          cnt_op;
        logic             out_load;
        logic             out_entry;
        logic [IDX_W-1:0] out_index;
        status_t          out_status;
        logic             out_last;
    } ple_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } ple_stat_t;

    // values at or below zero become one
    function automatic logic [VAL_W-1:0] clamp_pos(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] r;
        r = v;
        if (v[VAL_W-1] || (v == '0)) begin
            r = VAL_W'(1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/ple_dpath.sv
// ---------------------------------------------------------------------------
// ple_dpath: storage and result datapath of the positional list engine
// entry memory with registered read, entry count, result register
// ---------------------------------------------------------------------------
module ple_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ple_pkg::VAL_W-1:0]         in_value,
    input  ple_pkg::ple_cmd_t                 cmd,
    output ple_pkg::ple_stat_t                stat,
    output logic [ple_pkg::VAL_W-1:0]         out_value,
    output logic [ple_pkg::EIDX_W-1:0]        out_index,
    output logic [ple_pkg::ECNT_W-1:0]        out_count,
    output logic [ple_pkg::ST_W-1:0]          out_status,
    output logic                              out_last
);

    logic [ple_pkg::VAL_W-1:0]  mem [ple_pkg::DEPTH];
    logic [ple_pkg::VAL_W-1:0]  rdata_reg;
    logic [ple_pkg::VAL_W-1:0]  value_reg;
    logic [ple_pkg::VAL_W-1:0]  wr_data;
    logic [ple_pkg::CNT_W-1:0]  count_reg;
    logic [ple_pkg::CNT_W-1:0]  count_next;

    logic [ple_pkg::VAL_W-1:0]  out_value_reg;
    logic [ple_pkg::EIDX_W-1:0] out_index_reg;
    logic [ple_pkg::ECNT_W-1:0] out_count_reg;
    logic [ple_pkg::ST_W-1:0]   out_status_reg;
    logic                       out_last_reg;

    always_comb begin
        unique case (cmd.wr_src)
            ple_pkg::WR_VALUE: wr_data = value_reg;
            ple_pkg::WR_RDATA: wr_data = rdata_reg;
            ple_pkg::WR_CLAMP: wr_data = ple_pkg::clamp_pos(rdata_reg);
            default:           wr_data = rdata_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.cnt_op)
            ple_pkg::CNT_INC: count_next = count_reg + 1'b1;
            ple_pkg::CNT_DEC: count_next = count_reg - 1'b1;
            default:          count_next = count_reg;
        endcase
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.val_load) begin
            value_reg <= in_value;
        end
        if (cmd.out_load) begin
            out_value_reg  <= cmd.out_entry ? rdata_reg : '0;
            out_index_reg  <= ple_pkg::EIDX_W'(cmd.out_index);
            out_count_reg  <= ple_pkg::ECNT_W'(count_reg);
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign stat.count = count_reg;
    assign out_value  = out_value_reg;
    assign out_index  = out_index_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: rtl/core/ple_ctrl.sv
// ---------------------------------------------------------------------------
// ple_ctrl: sequencer of the positional list engine
// decodes an action, walks the entries and drives the result handshake
// ---------------------------------------------------------------------------
module ple_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ple_pkg::ACT_W-1:0]     s_action,
    input  logic [ple_pkg::POS_W-1:0]     s_position,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  ple_pkg::ple_stat_t            stat,
    output ple_pkg::ple_cmd_t             cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_DRD,
        S_DOUT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        M_INS,
        M_RM,
        M_CLAMP
    } mode_t;

    state_t                    state_reg,  state_next;
    mode_t                     mode_reg,   mode_next;
    logic [ple_pkg::CNT_W-1:0] cur_reg,    cur_next;
    logic [ple_pkg::CNT_W-1:0] end_reg,    end_next;
    logic [ple_pkg::CNT_W-1:0] wptr_reg,   wptr_next;
    logic                      wvld_reg,   wvld_next;
    ple_pkg::status_t          status_reg, status_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic                          accept;
    logic                          out_free;
    logic                          issue;
    logic                          full;
    logic                          empty;
    logic                          dump_last;
    logic [ple_pkg::CNT_W-1:0]     src;
    logic [ple_pkg::CNT_W-1:0]     ins_idx;
    logic [ple_pkg::CNT_W-1:0]     rm_idx;
    logic [ple_pkg::ECNT_W-1:0]    pos_x;
    logic [ple_pkg::ECNT_W-1:0]    cnt_x;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign full      = (stat.count == ple_pkg::CNT_W'(ple_pkg::DEPTH));
    assign empty     = (stat.count == '0);
    assign issue     = (cur_reg != end_reg);
    assign dump_last = (cur_reg == stat.count - 1'b1);
    assign pos_x     = ple_pkg::ECNT_W'(s_position);
    assign cnt_x     = ple_pkg::ECNT_W'(stat.count);

    // insert target: past the end appends
    always_comb begin
        if (pos_x >= cnt_x) begin
            ins_idx = stat.count;
        end else begin
            ins_idx = pos_x[ple_pkg::CNT_W-1:0];
        end
    end

    // remove target: one-based, clipped to front and back
    always_comb begin
        priority if (pos_x <= ple_pkg::ECNT_W'(1)) begin
            rm_idx = '0;
        end else if (pos_x >= cnt_x) begin
            rm_idx = stat.count - 1'b1;
        end else begin
            rm_idx = pos_x[ple_pkg::CNT_W-1:0] - 1'b1;
        end
    end

    // source of the entry moved into cur_reg
    always_comb begin
        unique case (mode_reg)
            M_INS:   src = cur_reg - 1'b1;
            M_RM:    src = cur_reg + 1'b1;
            default: src = cur_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        wptr_next     = wptr_reg;
        wvld_next     = 1'b0;
        status_next   = status_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        cmd           = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.val_load = 1'b1;
                    status_next  = ple_pkg::ST_OK;
                    unique case (ple_pkg::action_t'(s_action))
                        ple_pkg::ACT_INS_FRONT,
                        ple_pkg::ACT_INS_BACK,
                        ple_pkg::ACT_INS_AT: begin
                            mode_next = M_INS;
                            cur_next  = stat.count;
                            if (ple_pkg::action_t'(s_action) == ple_pkg::ACT_INS_FRONT) begin
                                end_next = '0;
                            end else if (ple_pkg::action_t'(s_action) == ple_pkg::ACT_INS_BACK) begin
                                end_next = stat.count;
                            end else begin
                                end_next = ins_idx;
                            end
                            if (full) begin
                                status_next = ple_pkg::ST_FULL;
                                state_next  = S_EMIT;
                            end else begin
                                state_next  = S_WALK;
                            end
                        end
                        ple_pkg::ACT_RM_FRONT,
                        ple_pkg::ACT_RM_BACK,
                        ple_pkg::ACT_RM_AT: begin
                            mode_next = M_RM;
                            end_next  = stat.count - 1'b1;
                            if (ple_pkg::action_t'(s_action) == ple_pkg::ACT_RM_FRONT) begin
                                cur_next = '0;
                            end else if (ple_pkg::action_t'(s_action) == ple_pkg::ACT_RM_BACK) begin
                                cur_next = stat.count - 1'b1;
                            end else begin
                                cur_next = rm_idx;
                            end
                            if (empty) begin
                                status_next = ple_pkg::ST_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                state_next  = S_WALK;
                            end
                        end
                        ple_pkg::ACT_CLAMP: begin
                            mode_next  = M_CLAMP;
                            cur_next   = '0;
                            end_next   = stat.count;
                            state_next = S_WALK;
                        end
                        ple_pkg::ACT_DUMP: begin
                            cur_next = '0;
                            if (empty) begin
                                status_next = ple_pkg::ST_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                state_next  = S_DRD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            // one entry per cycle: read source now, write destination next cycle
            S_WALK: begin
                if (wvld_reg) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = wptr_reg[ple_pkg::IDX_W-1:0];
                    cmd.wr_src  = (mode_reg == M_CLAMP) ? ple_pkg::WR_CLAMP
                                                        : ple_pkg::WR_RDATA;
                end
                if (issue) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = src[ple_pkg::IDX_W-1:0];
                    wptr_next   = cur_reg;
                    wvld_next   = 1'b1;
                    cur_next    = (mode_reg == M_INS) ? cur_reg - 1'b1 : cur_reg + 1'b1;
                end else if (!wvld_reg) begin
                    state_next = (mode_reg == M_CLAMP) ? S_EMIT : S_FIN;
                end
            end

            S_FIN: begin
                if (mode_reg == M_INS) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = cur_reg[ple_pkg::IDX_W-1:0];
                    cmd.wr_src  = ple_pkg::WR_VALUE;
                    cmd.cnt_op  = ple_pkg::CNT_INC;
                end else begin
                    cmd.cnt_op  = ple_pkg::CNT_DEC;
                end
                state_next = S_EMIT;
            end

            S_DRD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = cur_reg[ple_pkg::IDX_W-1:0];
                state_next  = S_DOUT;
            end

            S_DOUT: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_entry  = 1'b1;
                    cmd.out_index  = cur_reg[ple_pkg::IDX_W-1:0];
                    cmd.out_status = ple_pkg::ST_OK;
                    cmd.out_last   = dump_last;
                    m_tvalid_next  = 1'b1;
                    cur_next       = cur_reg + 1'b1;
                    state_next     = dump_last ? S_IDLE : S_DRD;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = status_reg;
                    cmd.out_last   = 1'b1;
                    m_tvalid_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_INS;
            cur_reg      <= '0;
            end_reg      <= '0;
            wptr_reg     <= '0;
            wvld_reg     <= 1'b0;
            status_reg   <= ple_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cur_reg      <= cur_next;
            end_reg      <= end_next;
            wptr_reg     <= wptr_next;
            wvld_reg     <= wvld_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while waiting");

    // writes stay inside the live list or one past it
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (ple_pkg::CNT_W'(cmd.wr_addr) <= stat.count))
        else $error("write beyond the end of the list");

    // entry count bounded by capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
        else $error("entry count above capacity");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second item taken before the first finished");

endmodule

FILE: rtl/core/positional_list_engine_unit.sv
// ---------------------------------------------------------------------------
// positional_list_engine_unit: bounded ordered list of signed 32-bit values
// insert/remove at front, back or position, clamp to positive, dump in order
// ---------------------------------------------------------------------------
//
//  channel  dir  tdata fields (lsb first)                            tlast
//  s_       in   action[2:0] value[34:3] position[40:35] zero[47:41]  -
//  m_       out  entry_value[31:0] entry_index[37:32]                 last
//                count[44:38] status[46:45] zero[47]
//
//  one item at a time; s_tready is high only while the sequencer is idle
//  insert or remove: entries are shifted one at a time, one entry moved per cycle,
//    then the value is written or the count dropped; full or empty returns only a status
//  clamp: every entry is clamped in place; dump: each entry is read, then emitted in order
//  a full result register stalls the sequencer until m_tready takes the beat
//  aresetn clears the count and control; the entry memory itself is not cleared
//
module positional_list_engine_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0]     s_tdata,   // action, value, position
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0]     m_tdata,   // entry_value, entry_index, count, status
    output logic                              m_tlast
);

    localparam int unsigned VAL_LO = ple_pkg::ACT_W;
    localparam int unsigned POS_LO = VAL_LO + ple_pkg::VAL_W;
    localparam int unsigned M_USED = ple_pkg::VAL_W + ple_pkg::EIDX_W
                                   + ple_pkg::ECNT_W + ple_pkg::ST_W;

    ple_pkg::ple_cmd_t  cmd;
    ple_pkg::ple_stat_t stat;

    logic [ple_pkg::ACT_W-1:0]  s_action;
    logic [ple_pkg::VAL_W-1:0]  s_value;
    logic [ple_pkg::POS_W-1:0]  s_position;

    logic [ple_pkg::VAL_W-1:0]  out_value;
    logic [ple_pkg::EIDX_W-1:0] out_index;
    logic [ple_pkg::ECNT_W-1:0] out_count;
    logic [ple_pkg::ST_W-1:0]   out_status;

    // unpack input beat; padding bits are ignored
    assign s_action   = s_tdata[ple_pkg::ACT_W-1:0];
    assign s_value    = s_tdata[POS_LO-1:VAL_LO];
    assign s_position = s_tdata[POS_LO+ple_pkg::POS_W-1:POS_LO];

    // sequencer: decode, walk and handshakes
    ple_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_action   (s_action),
        .s_position (s_position),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // entry memory, count and result register
    ple_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_value   (s_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_value  (out_value),
        .out_index  (out_index),
        .out_count  (out_count),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    // pack result beat, zero fill to whole bytes
    assign m_tdata = {{(ple_pkg::M_TDATA_W - M_USED){1'b0}},
                      out_status, out_count, out_index, out_value};

endmodule
